// ----- hdl/occn_pkg.sv -----
// ----------------------------------------------------------------------------
// occn_pkg: shared types and constants for the occupancy notifier
// Holds the event codes, sleep codes, register indexes, the phase type and
// the structs passed between the configuration registers and the core.
// ----------------------------------------------------------------------------
package occn_pkg;

   // Event codes carried with each input item.
   localparam logic [2:0] FN_TICK = 3'd0;
   localparam logic [2:0] FN_RX   = 3'd1;
   localparam logic [2:0] FN_LID  = 3'd2;
   localparam logic [2:0] FN_DOOR = 3'd3;
   localparam logic [2:0] FN_WAKE = 3'd4;

   // Sleep mode requests.
   localparam logic [1:0] SLP_AWAKE = 2'd0;
   localparam logic [1:0] SLP_ANY   = 2'd1;
   localparam logic [1:0] SLP_DOOR  = 2'd2;
   localparam logic [1:0] SLP_LID   = 2'd3;

   // Configuration register indexes.
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 16;
   localparam logic [CSR_ADDR_W-1:0] CSR_ACK_CODE      = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FULL_CODE     = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_EMPTY_CODE    = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_RETRY_TIMEOUT = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_RETRIES   = 3'd4;

   // Reset values of the configuration registers.
   localparam logic [7:0]  RST_ACK_CODE      = 8'h25;
   localparam logic [7:0]  RST_FULL_CODE     = 8'h55;
   localparam logic [7:0]  RST_EMPTY_CODE    = 8'hAA;
   localparam logic [15:0] RST_RETRY_TIMEOUT = 16'd1000;
   localparam logic [3:0]  RST_MAX_RETRIES   = 4'd5;

   localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

   typedef enum logic [1:0] {
      PH_READY,
      PH_WAIT_FULL,
      PH_WAIT_EMPTY
   } phase_type;

   typedef struct packed {
      logic [7:0]  ack_code;
      logic [7:0]  full_code;
      logic [7:0]  empty_code;
      logic [15:0] retry_timeout;
      logic [3:0]  max_retries;
   } cfg_type;

   typedef struct packed {
      logic       gave_up;
      logic       box_full;
      logic [1:0] sleep_request;
      logic [7:0] send_byte;
      logic       send_valid;
   } result_type;

endpackage

// ----- hdl/occn_csr.sv -----
// ----------------------------------------------------------------------------
// occn_csr: configuration registers
// Five write-only registers loaded through a plain write port; writes to an
// index beyond the list are dropped.
// ----------------------------------------------------------------------------
module occn_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [occn_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [occn_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output occn_pkg::cfg_type                cfg
);
   import occn_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_ACK_CODE:      cfg_in.ack_code      = csr_wdata[7:0];
            CSR_FULL_CODE:     cfg_in.full_code     = csr_wdata[7:0];
            CSR_EMPTY_CODE:    cfg_in.empty_code    = csr_wdata[7:0];
            CSR_RETRY_TIMEOUT: cfg_in.retry_timeout = csr_wdata[15:0];
            CSR_MAX_RETRIES:   cfg_in.max_retries   = csr_wdata[3:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ack_code      <= RST_ACK_CODE;
         cfg_ff.full_code     <= RST_FULL_CODE;
         cfg_ff.empty_code    <= RST_EMPTY_CODE;
         cfg_ff.retry_timeout <= RST_RETRY_TIMEOUT;
         cfg_ff.max_retries   <= RST_MAX_RETRIES;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hdl/occn_core.sv -----
// ----------------------------------------------------------------------------
// occn_core: notifier state and per-item update
// Holds the phase, box status, sticky acknowledge flag, retry count and
// elapsed tick counter, and works out the result for one item.
// ----------------------------------------------------------------------------
module occn_core (
   input  logic                   clock,
   input  logic                   reset,
   input  occn_pkg::cfg_type      cfg,
   input  logic                   step,
   input  logic [2:0]             func,
   input  logic [7:0]             rx_byte,
   output occn_pkg::result_type   result
);
   import occn_pkg::*;

   phase_type   phase_ff,   phase_in;
   logic        full_ff,    full_in;
   logic        ack_ff,     ack_in;
   logic [3:0]  retry_ff,   retry_in;
   logic [15:0] elapsed_ff, elapsed_in;

   logic        waiting;
   logic [15:0] elapsed_inc;
   logic [7:0]  report_code;

   assign waiting     = (phase_ff != PH_READY);
   assign elapsed_inc = (elapsed_ff == ELAPSED_MAX) ? elapsed_ff : elapsed_ff + 16'd1;
   assign report_code = (phase_ff == PH_WAIT_FULL) ? cfg.full_code : cfg.empty_code;

   always_comb begin
      phase_in   = phase_ff;
      full_in    = full_ff;
      ack_in     = ack_ff;
      retry_in   = retry_ff;
      elapsed_in = elapsed_ff;
      result     = '0;

      unique case (func)
         FN_RX: begin
            if (rx_byte == cfg.ack_code) begin
               ack_in = 1'b1;
            end
         end
         FN_TICK: begin
            if (waiting) begin
               if (ack_ff) begin
                  full_in              = (phase_ff == PH_WAIT_FULL);
                  phase_in             = PH_READY;
                  retry_in             = '0;
                  elapsed_in           = '0;
                  ack_in               = 1'b0;
                  result.sleep_request = (phase_ff == PH_WAIT_FULL) ? SLP_DOOR : SLP_LID;
               end else begin
                  elapsed_in = elapsed_inc;
                  if ((elapsed_inc > cfg.retry_timeout) && (retry_ff < cfg.max_retries)) begin
                     result.send_valid = 1'b1;
                     result.send_byte  = report_code;
                     retry_in          = retry_ff + 4'd1;
                     elapsed_in        = '0;
                  end
                  // Retry budget used up: finish without acknowledgement.
                  if (retry_in >= cfg.max_retries) begin
                     full_in              = (phase_ff == PH_WAIT_FULL);
                     phase_in             = PH_READY;
                     retry_in             = '0;
                     elapsed_in           = '0;
                     ack_in               = 1'b0;
                     result.sleep_request = (phase_ff == PH_WAIT_FULL) ? SLP_DOOR : SLP_LID;
                     result.gave_up       = 1'b1;
                  end
               end
            end
         end
         FN_LID: begin
            if (!waiting) begin
               if (!full_ff) begin
                  phase_in          = PH_WAIT_FULL;
                  retry_in          = '0;
                  elapsed_in        = '0;
                  result.send_valid = 1'b1;
                  result.send_byte  = cfg.full_code;
               end else begin
                  result.sleep_request = SLP_DOOR;
               end
            end
         end
         FN_DOOR: begin
            if (!waiting) begin
               if (full_ff) begin
                  phase_in          = PH_WAIT_EMPTY;
                  retry_in          = '0;
                  elapsed_in        = '0;
                  result.send_valid = 1'b1;
                  result.send_byte  = cfg.empty_code;
               end else begin
                  result.sleep_request = SLP_LID;
               end
            end
         end
         FN_WAKE: begin
            if (!waiting) begin
               result.sleep_request = SLP_ANY;
            end
         end
         default: begin
            result.sleep_request = SLP_AWAKE;
         end
      endcase

      result.box_full = full_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_READY;
         full_ff    <= 1'b0;
         ack_ff     <= 1'b0;
         retry_ff   <= '0;
         elapsed_ff <= '0;
      end else if (step) begin
         phase_ff   <= phase_in;
         full_ff    <= full_in;
         ack_ff     <= ack_in;
         retry_ff   <= retry_in;
         elapsed_ff <= elapsed_in;
      end
   end

endmodule

// ----- hdl/occupancy_notifier_with_retry.sv -----
// ----------------------------------------------------------------------------
// occupancy_notifier_with_retry: box occupancy reporter with retransmission
// Records whether a box is full or empty, reports changes as a code byte
// over a link and retransmits until acknowledged or out of retries.
// ----------------------------------------------------------------------------
// The block takes one event item per clock cycle while the result side does
// not stall, and returns exactly one result item for each, in order. An
// accepted item is held in an input register. While it is held, the core
// works out its result from the recorded state and the configuration. When
// the item advances, the core updates the state and the result register is
// loaded; the advance waits while the result register holds an item that is
// not being taken.
// Both stages advance together whenever the result register is empty or its
// item is being taken, so with rsp_tready held high the throughput is one
// item per cycle and the only thing that slows it is back-pressure on the
// result side. Configuration registers are written through the csr_ port
// and should only be changed while no item is in flight.
// ----------------------------------------------------------------------------
module occupancy_notifier_with_retry (
   input  logic                             clock,
   input  logic                             reset,
   // Event items.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,   // [7:0] rx_byte
   input  logic [2:0]                       req_tuser,   // [2:0] func
   // Result items.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [0] send_valid, [8:1] send_byte, [10:9] sleep_request, [11] box_full,
   // [12] gave_up, [15:13] zero
   output logic [15:0]                      rsp_tdata,
   // Configuration writes.
   input  logic                             csr_we,
   input  logic [occn_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [occn_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import occn_pkg::*;

   cfg_type    cfg;
   result_type result;

   logic       in_valid_ff;
   logic [2:0] in_func_ff;
   logic [7:0] in_rx_ff;

   logic       out_valid_ff;
   result_type out_result_ff;

   logic       advance;
   logic       req_fire;

   // The core step happens when a held item can move into the result register.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   occn_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   occn_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .step    (advance),
      .func    (in_func_ff),
      .rx_byte (in_rx_ff),
      .result  (result)
   );

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_func_ff <= req_tuser;
         in_rx_ff   <= req_tdata;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_result_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_result_ff};

endmodule

// ----- tb/tb_occupancy_notifier_with_retry.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_occupancy_notifier_with_retry: self-checking bench for the box notifier
// Drives event items with random bursts and gaps and stalls the result side on
// a pattern of its own. A behavioural predictor of the reporting and retry
// scheme works out every expected result item, and a scoreboard checks each
// result field by field against the oldest expectation.
// ----------------------------------------------------------------------------
module tb_occupancy_notifier_with_retry;
   import occn_pkg::*;

   // The run is stopped as a failure if it goes on longer than this.
   localparam int unsigned CYCLE_LIMIT = 1000000;
   // Cycles allowed for the outstanding results to come back when draining.
   localparam int unsigned DRAIN_LIMIT = 2000;
   // Mismatch lines printed before the rest are only counted.
   localparam int unsigned PRINT_LIMIT = 30;
   // Event codes that the block leaves unused.
   localparam logic [2:0] FN_SPARE_FIRST = 3'd5;
   localparam logic [2:0] FN_SPARE_LAST  = 3'd7;
   // A register index that maps to no register.
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE = 3'd7;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;
   logic [2:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [15:0]           rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   occupancy_notifier_with_retry dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // The predictor's own copy of the registers and the reporting state.
   cfg_type     m_cfg;
   phase_type   m_phase;
   logic        m_full;
   logic        m_ack;
   logic [3:0]  m_retries;
   logic [15:0] m_elapsed;

   // Results owed by the block, oldest first.
   result_type owed_results[$];

   int unsigned mismatches   = 0;
   int unsigned results_seen = 0;
   int unsigned items_sent   = 0;
   int unsigned cycle_count  = 0;
   int unsigned burst_left   = 0;
   bit          tx_gaps_on    = 1'b1;
   bit          rsp_stalls_on = 1'b1;

   // The settings currently written, kept so that stimulus can aim at them.
   logic [7:0]  cur_ack;
   logic [15:0] cur_tmo;
   logic [3:0]  cur_tries;

   initial begin : clock_gen
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("occupancy_notifier_with_retry regression: fail");
         $finish;
      end
   end

   // The receiver alternates runs of readiness with stalls; most stalls are
   // short, but now and then a long one lets the block fill up behind it.
   initial begin : rsp_stall_pattern
      int unsigned run;
      forever begin
         rsp_tready <= 1'b1;
         run = $urandom_range(1, 24);
         repeat (run) @(posedge clock);
         if (rsp_stalls_on) begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
            rsp_tready <= 1'b0;
            repeat (run) @(posedge clock);
         end
      end
   end

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("%0t: result %0d: %s is %0h, expected %0h",
                  $time, results_seen, what, got, want);
   endtask

   // A report ends here, whether acknowledged or abandoned. The recorded
   // status follows the report and the matching sleep mode is requested.
   function automatic void close_report(inout result_type r, input logic gave);
      m_full    = (m_phase == PH_WAIT_FULL);
      m_phase   = PH_READY;
      m_retries = '0;
      m_elapsed = '0;
      m_ack     = 1'b0;
      r.sleep_request = m_full ? SLP_DOOR : SLP_LID;
      r.gave_up       = gave;
   endfunction

   function automatic result_type predict_event(input logic [2:0] fn, input logic [7:0] rx);
      result_type r;
      logic       waiting;
      r       = '0;
      waiting = (m_phase != PH_READY);
      case (fn)
         FN_RX: begin
            // The acknowledge is sticky, even when it arrives before a report.
            if (rx == m_cfg.ack_code)
               m_ack = 1'b1;
         end
         FN_TICK: begin
            if (waiting) begin
               if (m_ack) begin
                  close_report(r, 1'b0);
               end else begin
                  if (m_elapsed != ELAPSED_MAX)
                     m_elapsed++;
                  if (m_elapsed > m_cfg.retry_timeout && m_retries < m_cfg.max_retries) begin
                     r.send_valid = 1'b1;
                     r.send_byte  = (m_phase == PH_WAIT_FULL) ? m_cfg.full_code
                                                              : m_cfg.empty_code;
                     m_retries++;
                     m_elapsed = '0;
                  end
                  // A budget of zero gives up on the very first tick.
                  if (m_retries >= m_cfg.max_retries)
                     close_report(r, 1'b1);
               end
            end
         end
         FN_LID: begin
            if (!waiting) begin
               if (!m_full) begin
                  m_phase      = PH_WAIT_FULL;
                  m_retries    = '0;
                  m_elapsed    = '0;
                  r.send_valid = 1'b1;
                  r.send_byte  = m_cfg.full_code;
               end else begin
                  r.sleep_request = SLP_DOOR;
               end
            end
         end
         FN_DOOR: begin
            if (!waiting) begin
               if (m_full) begin
                  m_phase      = PH_WAIT_EMPTY;
                  m_retries    = '0;
                  m_elapsed    = '0;
                  r.send_valid = 1'b1;
                  r.send_byte  = m_cfg.empty_code;
               end else begin
                  r.sleep_request = SLP_LID;
               end
            end
         end
         FN_WAKE: begin
            if (!waiting)
               r.sleep_request = SLP_ANY;
         end
         default: ;
      endcase
      r.box_full = m_full;
      return r;
   endfunction

   // The scoreboard checks each result as it is taken, then follows any
   // register write and predicts the result of any item accepted at this edge.
   always @(posedge clock) begin : scoreboard
      result_type got;
      result_type want;
      if (reset) begin
         m_cfg.ack_code      = RST_ACK_CODE;
         m_cfg.full_code     = RST_FULL_CODE;
         m_cfg.empty_code    = RST_EMPTY_CODE;
         m_cfg.retry_timeout = RST_RETRY_TIMEOUT;
         m_cfg.max_retries   = RST_MAX_RETRIES;
         m_phase   = PH_READY;
         m_full    = 1'b0;
         m_ack     = 1'b0;
         m_retries = '0;
         m_elapsed = '0;
         owed_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[12:0]);
            results_seen++;
            if (owed_results.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata, 0);
            end else begin
               want = owed_results.pop_front();
               if (got.send_valid != want.send_valid)
                  report_mismatch("send_valid", got.send_valid, want.send_valid);
               if (got.send_byte != want.send_byte)
                  report_mismatch("send_byte", got.send_byte, want.send_byte);
               if (got.sleep_request != want.sleep_request)
                  report_mismatch("sleep_request", got.sleep_request, want.sleep_request);
               if (got.box_full != want.box_full)
                  report_mismatch("box_full", got.box_full, want.box_full);
               if (got.gave_up != want.gave_up)
                  report_mismatch("gave_up", got.gave_up, want.gave_up);
               if (rsp_tdata[15:13] != '0)
                  report_mismatch("padding", rsp_tdata[15:13], 0);
            end
         end
         if (csr_we) begin
            case (csr_addr)
               CSR_ACK_CODE:      m_cfg.ack_code      = csr_wdata[7:0];
               CSR_FULL_CODE:     m_cfg.full_code     = csr_wdata[7:0];
               CSR_EMPTY_CODE:    m_cfg.empty_code    = csr_wdata[7:0];
               CSR_RETRY_TIMEOUT: m_cfg.retry_timeout = csr_wdata[15:0];
               CSR_MAX_RETRIES:   m_cfg.max_retries   = csr_wdata[3:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            owed_results.push_back(predict_event(req_tuser, req_tdata));
      end
   end

   // Offers one item and returns at the edge that takes it. The sender keeps
   // tvalid high through a burst and drops it for a random gap between bursts.
   task automatic send_event(input logic [2:0] fn, input logic [7:0] rx);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tuser  <= fn;
      req_tdata  <= rx;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (burst_left != 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 15);
         if (tx_gaps_on) begin
            gap = $urandom_range(1, 6);
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Stops sending, waits for every owed result and then idles before returning.
   task automatic wait_drained;
      int unsigned guard;
      guard = 0;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (owed_results.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      if (owed_results.size() != 0) begin
         report_mismatch("results never returned", owed_results.size(), 0);
         owed_results.delete();
      end
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Writes every register once the block is idle. The bits above a narrow
   // register carry noise, which the block must drop.
   task automatic apply_config(input logic [7:0] ack, input logic [7:0] full,
                               input logic [7:0] empty, input logic [15:0] tmo,
                               input logic [3:0] tries);
      wait_drained;
      write_reg(CSR_ACK_CODE,      {8'($urandom), ack});
      write_reg(CSR_FULL_CODE,     {8'($urandom), full});
      write_reg(CSR_EMPTY_CODE,    {8'($urandom), empty});
      write_reg(CSR_RETRY_TIMEOUT, tmo);
      write_reg(CSR_MAX_RETRIES,   {12'($urandom), tries});
      cur_ack   = ack;
      cur_tmo   = tmo;
      cur_tries = tries;
   endtask

   // Works from the register values left by reset: every kind of event in the
   // ready phase, reports closed by an acknowledge, and an acknowledge that
   // arrives before its report and closes it on the first tick.
   task automatic test_default_registers;
      send_event(FN_TICK, 8'h00);
      for (int c = FN_SPARE_FIRST; c <= FN_SPARE_LAST; c++)
         send_event(3'(c), 8'hFF);
      send_event(FN_WAKE, 8'h00);
      send_event(FN_DOOR, 8'h00);
      send_event(FN_RX, 8'h00);
      send_event(FN_LID, 8'h00);
      send_event(FN_TICK, 8'h00);
      send_event(FN_WAKE, 8'h00);
      send_event(FN_LID, 8'h00);
      send_event(FN_RX, RST_ACK_CODE);
      send_event(FN_TICK, 8'h00);
      send_event(FN_LID, 8'h00);
      send_event(FN_DOOR, 8'h00);
      send_event(FN_RX, 8'hFF);
      send_event(FN_RX, RST_ACK_CODE);
      send_event(FN_TICK, 8'h00);
      send_event(FN_RX, RST_ACK_CODE);
      send_event(FN_LID, 8'h00);
      send_event(FN_TICK, 8'h00);
   endtask

   // Extreme register values: a zero retry budget gives up on the first tick
   // unless an acknowledge is waiting, and the full budget of fifteen resends
   // runs out with the shortest timeout. One write goes to an unmapped index.
   task automatic test_register_extremes;
      apply_config(8'h00, 8'hFF, 8'h00, 16'd1, 4'd0);
      write_reg(CSR_SPARE, 16'hFFFF);
      send_event(FN_DOOR, 8'h00);
      send_event(FN_LID, 8'h00);
      send_event(FN_TICK, 8'h00);
      send_event(FN_RX, 8'h00);
      send_event(FN_DOOR, 8'h00);
      send_event(FN_LID, 8'h00);
      send_event(FN_TICK, 8'h00);
      apply_config(8'hFF, 8'h00, 8'hFF, 16'd1, 4'd15);
      send_event(FN_LID, 8'h00);
      send_event(FN_DOOR, 8'h00);
      for (int k = 0; k < 34; k++)
         send_event((k == 9) ? FN_RX : FN_TICK, 8'hFE);
      send_event(FN_RX, 8'hFF);
      send_event(FN_LID, 8'h00);
      send_event(FN_DOOR, 8'h00);
      send_event(FN_TICK, 8'h00);
   endtask

   // With the largest timeout no resend happens over a long stretch of ticks,
   // and the report closes only on an acknowledge. With a budget of one, the
   // resend that uses it up gives up in the same result.
   task automatic test_long_timeout;
      tx_gaps_on    = 1'b0;
      rsp_stalls_on = 1'b0;
      // A report closed with no budget clears any acknowledge left pending.
      apply_config(8'h5A, 8'h11, 8'h22, 16'd1, 4'd0);
      send_event(FN_LID, 8'h00);
      send_event(FN_DOOR, 8'h00);
      send_event(FN_TICK, 8'h00);
      apply_config(8'h5A, 8'h11, 8'h22, ELAPSED_MAX, 4'd1);
      send_event(FN_LID, 8'h00);
      send_event(FN_DOOR, 8'h00);
      repeat (40) send_event(FN_TICK, 8'h5A);
      send_event(FN_RX, 8'h5A);
      send_event(FN_TICK, 8'h00);
      apply_config(8'h5A, 8'h11, 8'h22, 16'd2, 4'd1);
      send_event(FN_LID, 8'h00);
      send_event(FN_DOOR, 8'h00);
      repeat (4) send_event(FN_TICK, 8'h00);
      tx_gaps_on    = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   // Phases of random traffic, each under fresh settings. Most of it is made
   // of report episodes: an event that may open a report, then a stretch of
   // ticks long enough to reach resends or give up, with an acknowledge
   // dropped in at a random point or left out, and noise mixed in.
   task automatic test_random_traffic;
      int unsigned phase_goal;
      int unsigned span;
      int unsigned ack_at;
      int unsigned pick;
      logic [7:0]  full;
      for (int p = 0; p < 11; p++) begin
         full = 8'($urandom);
         apply_config(($urandom_range(0, 3) == 0) ? full : 8'($urandom), full, 8'($urandom),
                      ($urandom_range(0, 7) == 0) ? 16'($urandom_range(6, 24))
                                                  : 16'($urandom_range(1, 5)),
                      4'($urandom_range(0, 15)));
         // Some phases run with no idling on one side or both.
         tx_gaps_on    = (p % 3) != 0;
         rsp_stalls_on = (p % 4) != 1;
         phase_goal = items_sent + 100;
         while (items_sent < phase_goal) begin
            pick = $urandom_range(0, 9);
            if (pick < 8)
               send_event($urandom_range(0, 1) ? FN_LID : FN_DOOR, 8'($urandom));
            else if (pick == 8)
               send_event(FN_WAKE, 8'($urandom));
            else
               send_event(3'($urandom_range(FN_SPARE_FIRST, FN_SPARE_LAST)), 8'($urandom));
            span = (int'(cur_tmo) + 1) * (int'(cur_tries) + 1) + 3;
            if (span > 90)
               span = 90;
            span   = $urandom_range(0, span);
            ack_at = ($urandom_range(0, 2) == 0) ? span : $urandom_range(0, span);
            for (int k = 0; k < span; k++) begin
               pick = $urandom_range(0, 19);
               if (k == ack_at || pick == 16)
                  send_event(FN_RX, cur_ack);
               else if (pick < 14)
                  send_event(FN_TICK, 8'($urandom));
               else if (pick < 16)
                  send_event(FN_RX, 8'($urandom));
               else if (pick == 17)
                  send_event($urandom_range(0, 1) ? FN_LID : FN_DOOR, 8'($urandom));
               else if (pick == 18)
                  send_event(FN_WAKE, 8'($urandom));
               else
                  send_event(3'($urandom_range(FN_SPARE_FIRST, FN_SPARE_LAST)),
                             8'($urandom));
            end
         end
      end
   endtask

   initial begin : main
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_default_registers;
      test_register_extremes;
      test_long_timeout;
      test_random_traffic;
      wait_drained;
      if (mismatches == 0) begin
         $display("occupancy_notifier_with_retry regression: pass");
      end else begin
         $display("occupancy_notifier_with_retry regression: fail");
      end
      $finish;
   end

endmodule
